/* hw/rtl/hra_pkg.sv */
// Package for the RGB hue rotation block: shared constants, codes and the
// sideband struct that travels through the pipeline. No dependencies.
`timescale 1ns / 1ps

package hra_pkg;

    // Hue cycle geometry: six stages of 255 positions
    localparam int STAGE_WIDTH     = 255;
    localparam int CYCLE_POSITIONS = 1530;

    // Step conversion: 1/64 degree to positions is a multiply by 17 and a shift by 8
    localparam int STEP_RATIO = 17;
    localparam int STEP_SHIFT = 8;

    // Channel that holds the maximum
    localparam logic [1:0] SECT_RED   = 2'd0;
    localparam logic [1:0] SECT_GREEN = 2'd1;
    localparam logic [1:0] SECT_BLUE  = 2'd2;

    // Output hue stages
    localparam logic [2:0] HS_RED_YELLOW   = 3'd0;
    localparam logic [2:0] HS_YELLOW_GREEN = 3'd1;
    localparam logic [2:0] HS_GREEN_CYAN   = 3'd2;
    localparam logic [2:0] HS_CYAN_BLUE    = 3'd3;
    localparam logic [2:0] HS_BLUE_MAGENTA = 3'd4;
    localparam logic [2:0] HS_MAGENTA_RED  = 3'd5;

    // Sideband that rides along the divider
    typedef struct packed {
        logic [1:0] sector;
        logic       hue_neg;
        logic       grey;
        logic       step_neg;
    } hra_side_t;

endpackage

/* hw/rtl/hra_front.sv */
// Front end of the hue rotation pipeline: max/min/delta, hue numerator and
// step conversion over two register stages. Depends on hra_pkg.
`timescale 1ns / 1ps

module hra_front
    import hra_pkg::*;
#(
    parameter int FRAC_BITS = 8,
    parameter int NUM_W     = 25,
    parameter int STEP_W    = 21
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [7:0]          in_red,
    input  logic [7:0]          in_green,
    input  logic [7:0]          in_blue,
    input  logic signed [16:0]  in_step,
    output logic                out_valid,
    output logic [NUM_W-1:0]    out_num,
    output logic [8:0]          out_den,
    output hra_side_t           out_side,
    output logic [STEP_W-1:0]   out_step_q
);

    localparam int WIDE_W     = FRAC_BITS + 22;
    localparam int ROUND_HALF = 1 << (STEP_SHIFT - 1);

    logic [1:0]        valid_reg;

    logic [7:0]        mx;
    logic [7:0]        mn;
    logic [1:0]        sect;
    logic signed [8:0] diff;
    logic [7:0]        mag_next;
    logic [16:0]       step_mag_next;
    hra_side_t         side_next;

    logic [7:0]        s1_mag_reg;
    logic [7:0]        s1_d_reg;
    hra_side_t         s1_side_reg;
    logic [16:0]       s1_step_mag_reg;

    logic [15:0]       mag255;
    logic [20:0]       m17;
    logic [WIDE_W-1:0] wide;
    logic [NUM_W-1:0]  num_next;
    logic [STEP_W-1:0] step_q_next;

    logic [NUM_W-1:0]  s2_num_reg;
    logic [8:0]        s2_den_reg;
    hra_side_t         s2_side_reg;
    logic [STEP_W-1:0] s2_step_q_reg;

    // Find max, min, the channel that wins and the signed hue numerator
    always_comb
    begin
        mx = in_red;
        if (in_green > mx)
            mx = in_green;
        if (in_blue > mx)
            mx = in_blue;
        mn = in_red;
        if (in_green < mn)
            mn = in_green;
        if (in_blue < mn)
            mn = in_blue;
        priority if (mx == in_red)
        begin
            sect = SECT_RED;
            diff = $signed({1'b0, in_green}) - $signed({1'b0, in_blue});
        end
        else if (mx == in_green)
        begin
            sect = SECT_GREEN;
            diff = $signed({1'b0, in_blue}) - $signed({1'b0, in_red});
        end
        else
        begin
            sect = SECT_BLUE;
            diff = $signed({1'b0, in_red}) - $signed({1'b0, in_green});
        end
        mag_next      = diff[8] ? 8'(-diff) : diff[7:0];
        step_mag_next = in_step[16] ? 17'(~in_step + 17'd1) : 17'(in_step);
        side_next.sector   = sect;
        side_next.hue_neg  = diff[8];
        side_next.grey     = (mx == mn);
        side_next.step_neg = in_step[16];
    end

    // Advance valid bits with the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[0], in_valid};
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mag_reg      <= mag_next;
            s1_d_reg        <= mx - mn;
            s1_side_reg     <= side_next;
            s1_step_mag_reg <= step_mag_next;
        end
    end

    // Scale the numerator for a rounded divide and convert the step to positions
    always_comb
    begin
        mag255      = {s1_mag_reg, 8'd0} - {8'd0, s1_mag_reg};
        num_next    = (NUM_W'(mag255) << (FRAC_BITS + 1)) + NUM_W'(s1_d_reg);
        m17         = 21'(s1_step_mag_reg) * 21'(STEP_RATIO);
        wide        = (WIDE_W'(m17) << FRAC_BITS) + WIDE_W'(ROUND_HALF);
        step_q_next = wide[STEP_SHIFT +: STEP_W];
    end

    // Stage 2 payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_num_reg    <= num_next;
            s2_den_reg    <= {s1_d_reg, 1'b0};
            s2_side_reg   <= s1_side_reg;
            s2_step_q_reg <= step_q_next;
        end
    end

    assign out_valid  = valid_reg[1];
    assign out_num    = s2_num_reg;
    assign out_den    = s2_den_reg;
    assign out_side   = s2_side_reg;
    assign out_step_q = s2_step_q_reg;

endmodule

/* hw/rtl/hra_div.sv */
// Pipelined restoring divider, one quotient bit per register stage, with a
// sideband and a tag carried alongside. Depends on hra_pkg.
`timescale 1ns / 1ps

module hra_div
    import hra_pkg::*;
#(
    parameter int NUM_W = 25,
    parameter int QUO_W = 16,
    parameter int TAG_W = 21
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [8:0]        in_den,
    input  hra_side_t         in_side,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_valid,
    output logic [QUO_W-1:0]  out_quo,
    output hra_side_t         out_side,
    output logic [TAG_W-1:0]  out_tag
);

    logic [QUO_W-1:0] valid_reg;
    logic [NUM_W-1:0] rem_reg  [QUO_W];
    logic [QUO_W-1:0] quo_reg  [QUO_W];
    logic [8:0]       den_reg  [QUO_W];
    hra_side_t        side_reg [QUO_W];
    logic [TAG_W-1:0] tag_reg  [QUO_W];

    // Shift valid bits along the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[QUO_W-2:0], in_valid};
    end

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_stage
        localparam int BIT = QUO_W - 1 - s;

        logic [NUM_W-1:0] rem_prev;
        logic [QUO_W-1:0] quo_prev;
        logic [8:0]       den_prev;
        hra_side_t        side_prev;
        logic [TAG_W-1:0] tag_prev;
        logic [NUM_W:0]   trial;
        logic [NUM_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        if (s == 0)
        begin : g_first
            assign rem_prev  = in_num;
            assign quo_prev  = '0;
            assign den_prev  = in_den;
            assign side_prev = in_side;
            assign tag_prev  = in_tag;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[s-1];
            assign quo_prev  = quo_reg[s-1];
            assign den_prev  = den_reg[s-1];
            assign side_prev = side_reg[s-1];
            assign tag_prev  = tag_reg[s-1];
        end

        // Try subtracting the shifted divisor; keep it when there is no borrow
        always_comb
        begin
            trial    = {1'b0, rem_prev} - ((NUM_W + 1)'(den_prev) << BIT);
            rem_next = trial[NUM_W] ? rem_prev : trial[NUM_W-1:0];
            quo_next = quo_prev;
            quo_next[BIT] = ~trial[NUM_W];
        end

        // Stage payload
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s]  <= rem_next;
                quo_reg[s]  <= quo_next;
                den_reg[s]  <= den_prev;
                side_reg[s] <= side_prev;
                tag_reg[s]  <= tag_prev;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];
    assign out_tag   = tag_reg[QUO_W-1];

endmodule

/* hw/rtl/hra_back.sv */
// Back end of the hue rotation pipeline: start position, step add, modulo
// wrap, stage split and saturated colour over eight stages. Depends on hra_pkg.
`timescale 1ns / 1ps

module hra_back
    import hra_pkg::*;
#(
    parameter int FRAC_BITS = 8,
    parameter int QUO_W     = 16,
    parameter int STEP_W    = 21
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [QUO_W-1:0]  in_quo,
    input  hra_side_t         in_side,
    input  logic [STEP_W-1:0] in_step_q,
    output logic              out_valid,
    output logic [7:0]        out_red,
    output logic [7:0]        out_green,
    output logic [7:0]        out_blue
);

    localparam int NS = 8;
    localparam int PW = FRAC_BITS + 14;

    localparam logic [PW-1:0] STAGE_LEN = PW'(STAGE_WIDTH) << FRAC_BITS;
    localparam logic [PW-1:0] CYCLE_LEN = PW'(CYCLE_POSITIONS) << FRAC_BITS;
    localparam logic [PW-1:0] CYCLE_X2  = PW'(2 * CYCLE_POSITIONS) << FRAC_BITS;
    localparam logic [PW-1:0] CYCLE_X3  = PW'(3 * CYCLE_POSITIONS) << FRAC_BITS;
    localparam logic [PW-1:0] CYCLE_X4  = PW'(4 * CYCLE_POSITIONS) << FRAC_BITS;
    localparam logic [PW-1:0] STAGE_X2  = PW'(2 * STAGE_WIDTH) << FRAC_BITS;
    localparam logic [PW-1:0] STAGE_X3  = PW'(3 * STAGE_WIDTH) << FRAC_BITS;
    localparam logic [PW-1:0] STAGE_X4  = PW'(4 * STAGE_WIDTH) << FRAC_BITS;
    localparam logic [PW-1:0] STAGE_X5  = PW'(5 * STAGE_WIDTH) << FRAC_BITS;
    localparam logic [PW-1:0] HALF_LSB  = PW'(1) << (FRAC_BITS - 1);

    logic [NS-1:0] valid_reg;

    logic [PW-1:0] qext;
    logic [PW-1:0] sq;
    logic [PW-1:0] base;
    logic [PW-1:0] start_next;
    logic [PW-1:0] soff_next;
    logic [PW-1:0] start_reg;
    logic [PW-1:0] soff_reg;
    logic [PW-1:0] sum_reg;
    logic [PW-1:0] mod4_reg;
    logic [PW-1:0] mod2_reg;
    logic [PW-1:0] pos_reg;
    logic [2:0]    hs_next;
    logic [2:0]    hs_reg;
    logic [PW-1:0] pos5_reg;
    logic [PW-1:0] hs_off;
    logic [PW-1:0] frac;
    logic [PW-1:0] rnd;
    logic [8:0]    fv9;
    logic [7:0]    fv_next;
    logic [2:0]    hs6_reg;
    logic [7:0]    fv_reg;
    logic [7:0]    inv;
    logic [7:0]    red_next;
    logic [7:0]    green_next;
    logic [7:0]    blue_next;
    logic [7:0]    red_reg;
    logic [7:0]    green_reg;
    logic [7:0]    blue_reg;

    // Shift valid bits along the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[NS-2:0], in_valid};
    end

    // Start position from the sector base and the signed hue term; step offset by CYCLE_X3
    always_comb
    begin
        qext = PW'(in_quo);
        sq   = PW'(in_step_q);
        unique case (in_side.sector)
            SECT_RED:   base = in_side.hue_neg ? CYCLE_LEN : '0;
            SECT_GREEN: base = STAGE_X2;
            SECT_BLUE:  base = STAGE_X4;
            default:    base = '0;
        endcase
        start_next = in_side.grey ? '0
                   : base + (in_side.hue_neg ? PW'(~qext + PW'(1)) : qext);
        soff_next  = CYCLE_X3 + (in_side.step_neg ? PW'(~sq + PW'(1)) : sq);
    end

    // Split the stage index out of the wrapped position
    always_comb
    begin
        priority if (pos_reg >= STAGE_X5)
            hs_next = HS_MAGENTA_RED;
        else if (pos_reg >= STAGE_X4)
            hs_next = HS_BLUE_MAGENTA;
        else if (pos_reg >= STAGE_X3)
            hs_next = HS_CYAN_BLUE;
        else if (pos_reg >= STAGE_X2)
            hs_next = HS_GREEN_CYAN;
        else if (pos_reg >= STAGE_LEN)
            hs_next = HS_YELLOW_GREEN;
        else
            hs_next = HS_RED_YELLOW;
    end

    // Remove the stage base, round to an 8-bit level and clamp
    always_comb
    begin
        unique case (hs_reg)
            HS_RED_YELLOW:   hs_off = '0;
            HS_YELLOW_GREEN: hs_off = STAGE_LEN;
            HS_GREEN_CYAN:   hs_off = STAGE_X2;
            HS_CYAN_BLUE:    hs_off = STAGE_X3;
            HS_BLUE_MAGENTA: hs_off = STAGE_X4;
            HS_MAGENTA_RED:  hs_off = STAGE_X5;
            default:         hs_off = '0;
        endcase
        frac    = pos5_reg - hs_off;
        rnd     = frac + HALF_LSB;
        fv9     = rnd[FRAC_BITS +: 9];
        fv_next = fv9[8] ? 8'd255 : fv9[7:0];
    end

    // Build the saturated colour for the stage
    always_comb
    begin
        inv = 8'd255 - fv_reg;
        unique case (hs6_reg)
            HS_RED_YELLOW:
            begin
                red_next = 8'd255; green_next = fv_reg; blue_next = 8'd0;
            end
            HS_YELLOW_GREEN:
            begin
                red_next = inv; green_next = 8'd255; blue_next = 8'd0;
            end
            HS_GREEN_CYAN:
            begin
                red_next = 8'd0; green_next = 8'd255; blue_next = fv_reg;
            end
            HS_CYAN_BLUE:
            begin
                red_next = 8'd0; green_next = inv; blue_next = 8'd255;
            end
            HS_BLUE_MAGENTA:
            begin
                red_next = fv_reg; green_next = 8'd0; blue_next = 8'd255;
            end
            default:
            begin
                red_next = 8'd255; green_next = 8'd0; blue_next = inv;
            end
        endcase
    end

    // Stage payloads: start and step offset, add, three wrap steps, stage split, level, colour
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            start_reg <= start_next;
            soff_reg  <= soff_next;
            sum_reg   <= start_reg + soff_reg;
            mod4_reg  <= (sum_reg >= CYCLE_X4) ? sum_reg - CYCLE_X4 : sum_reg;
            mod2_reg  <= (mod4_reg >= CYCLE_X2) ? mod4_reg - CYCLE_X2 : mod4_reg;
            pos_reg   <= (mod2_reg >= CYCLE_LEN) ? mod2_reg - CYCLE_LEN : mod2_reg;
            hs_reg    <= hs_next;
            pos5_reg  <= pos_reg;
            hs6_reg   <= hs_reg;
            fv_reg    <= fv_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;

endmodule

/* hw/rtl/hra_skid.sv */
// Output register with a one-entry skid buffer; its ready is registered and
// drives the pipeline advance. Depends on hra_pkg.
`timescale 1ns / 1ps

module hra_skid
    import hra_pkg::*;
#(
    parameter int DATA_W = 24
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [DATA_W-1:0] in_data,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [DATA_W-1:0] skid_data_reg;

    // Refill the output from the skid first; park a transaction in the skid on a stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= in_valid;
        end
        else if (in_valid && !skid_valid_reg)
            skid_valid_reg <= 1'b1;
    end

    // Payload moves with the same conditions
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        else if (in_valid && !skid_valid_reg)
            skid_data_reg <= in_data;
    end

    assign in_ready  = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* hw/rtl/rgb_hue_rotate.sv */
// Path from input transaction to output: front end, divider, back end and the skid output register.
// Throughput: one colour per cycle while the skid can take a transaction; the divider yields
// one quotient bit per stage, so its POSITION_FRAC_BITS + 8 stages set most of the latency.
// A one-entry skid at the output keeps input ready through a single output stall.
// Reset (rst_n low, asynchronous) clears all valid bits and the skid; data is not reset.
// Top level of the RGB hue rotation block. Depends on hra_pkg, hra_front, hra_div, hra_back, hra_skid.
`timescale 1ns / 1ps

module rgb_hue_rotate
    import hra_pkg::*;
#(
    parameter int POSITION_FRAC_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16],
                                        // hue_step[40:24], zero fill[47:41]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // red_out[7:0], green_out[15:8], blue_out[23:16]
);

    localparam int NUM_W  = POSITION_FRAC_BITS + 17;
    localparam int QUO_W  = POSITION_FRAC_BITS + 8;
    localparam int STEP_W = POSITION_FRAC_BITS + 13;

    logic              adv;
    logic              fr_valid;
    logic [NUM_W-1:0]  fr_num;
    logic [8:0]        fr_den;
    hra_side_t         fr_side;
    logic [STEP_W-1:0] fr_step_q;
    logic              dv_valid;
    logic [QUO_W-1:0]  dv_quo;
    hra_side_t         dv_side;
    logic [STEP_W-1:0] dv_step_q;
    logic              bk_valid;
    logic [7:0]        bk_red;
    logic [7:0]        bk_green;
    logic [7:0]        bk_blue;

    // Whole pipeline advances whenever the skid can take a transaction
    assign s_axis_tready = adv;

    hra_front #(
        .FRAC_BITS (POSITION_FRAC_BITS),
        .NUM_W     (NUM_W),
        .STEP_W    (STEP_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (s_axis_tvalid),
        .in_red     (s_axis_tdata[7:0]),
        .in_green   (s_axis_tdata[15:8]),
        .in_blue    (s_axis_tdata[23:16]),
        .in_step    ($signed(s_axis_tdata[40:24])),
        .out_valid  (fr_valid),
        .out_num    (fr_num),
        .out_den    (fr_den),
        .out_side   (fr_side),
        .out_step_q (fr_step_q)
    );

    hra_div #(
        .NUM_W (NUM_W),
        .QUO_W (QUO_W),
        .TAG_W (STEP_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fr_valid),
        .in_num    (fr_num),
        .in_den    (fr_den),
        .in_side   (fr_side),
        .in_tag    (fr_step_q),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side),
        .out_tag   (dv_step_q)
    );

    hra_back #(
        .FRAC_BITS (POSITION_FRAC_BITS),
        .QUO_W     (QUO_W),
        .STEP_W    (STEP_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (dv_valid),
        .in_quo    (dv_quo),
        .in_side   (dv_side),
        .in_step_q (dv_step_q),
        .out_valid (bk_valid),
        .out_red   (bk_red),
        .out_green (bk_green),
        .out_blue  (bk_blue)
    );

    hra_skid #(
        .DATA_W (24)
    ) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bk_valid),
        .in_data   ({bk_blue, bk_green, bk_red}),
        .in_ready  (adv),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

/* hw/rtl/hra_checker.sv */
// Port-level checker for rgb_hue_rotate and the bind that attaches it.
// Depends on rgb_hue_rotate.
`timescale 1ns / 1ps

module hra_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // Hold no output transaction while in reset
    assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("output valid during reset");

    // Keep a stalled output transaction presented
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped under stall");

    // Hold stalled output data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed under stall");

    // Drop input ready only while an output transaction is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no pending output");

    // Emit only fully saturated colours: one channel at full, one at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[7:0] == 8'd255 || m_axis_tdata[15:8] == 8'd255
                || m_axis_tdata[23:16] == 8'd255)
            && (m_axis_tdata[7:0] == 8'd0 || m_axis_tdata[15:8] == 8'd0
                || m_axis_tdata[23:16] == 8'd0))
        else $error("output colour not fully saturated");

endmodule

bind rgb_hue_rotate hra_checker u_hra_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
